// File: hdl/ehps_pkg.sv
// ---------------------------------------------------------------------------
// ecmp hash path select package
// Item types for the flow key and result channels, the remainder pipeline
// payload, and the fixed hash and protocol constants.
// ---------------------------------------------------------------------------
package ehps_pkg;

	// flow key item, one packet header
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [7:0]  protocol;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [6:0]  path_count;
	} key_t;

	// result item
	typedef struct packed {
		logic [31:0] flow_hash;
		logic [5:0]  path_index;
		logic        no_route;
	} res_t;

	// payload of the remainder stages
	typedef struct packed {
		logic [31:0] hash;
		logic [6:0]  rem;
		logic [6:0]  cnt;
	} mod_t;

	// remainder pipeline shape: hash bits consumed per stage and stage count
	localparam int unsigned MOD_BITS   = 8;
	localparam int unsigned MOD_STAGES = 32 / MOD_BITS;

	// murmur3 x86_32 constants
	localparam logic [31:0] C1        = 32'hcc9e2d51;
	localparam logic [31:0] C2        = 32'h1b873593;
	localparam logic [31:0] MIX_ADD   = 32'he6546b64;
	localparam logic [31:0] F1        = 32'h85ebca6b;
	localparam logic [31:0] F2        = 32'hc2b2ae35;
	localparam logic [31:0] KEY_BYTES = 32'd12;

	// protocols whose headers carry ports
	localparam logic [7:0] PROTO_TCP      = 8'h06;
	localparam logic [7:0] PROTO_UDP      = 8'h11;
	localparam logic [7:0] PROTO_PORTS_FC = 8'hFC;
	localparam logic [7:0] PROTO_PORTS_FD = 8'hFD;

endpackage

// File: hdl/ehps_mod_stage.sv
// ---------------------------------------------------------------------------
// ecmp hash path select remainder stage
// One register stage of the restoring remainder: folds MOD_BITS hash bits,
// most significant first, into the running remainder by the path count.
// ---------------------------------------------------------------------------
module ehps_mod_stage
	import ehps_pkg::*;
#(
	parameter int SLICE = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic prev_valid,
	input  mod_t prev,
	output logic valid_s1,
	output mod_t data_s1
);

	localparam int LoBit = 32 - MOD_BITS * (SLICE + 1);

	mod_t next;

	// eight shift and conditional subtract steps on the narrow remainder
	always_comb begin
		logic [7:0] t;
		logic [6:0] r;
		r = prev.rem;
		for (int i = MOD_BITS - 1; i >= 0; i--) begin
			t = {r, prev.hash[LoBit + i]};
			if (t >= {1'b0, prev.cnt}) begin
				t = t - {1'b0, prev.cnt};
			end
			r = t[6:0];
		end
		next      = prev;
		next.rem  = r;
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= prev_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (load && prev_valid) begin
			data_s1 <= next;
		end
	end

endmodule

// File: hdl/ecmp_hash_path_select.sv
// throughput: one item per cycle with no output stall; a stage takes a new item
// whenever it is empty or its successor moves, so bubbles close up under stall
// depth is set by the two key multiplies, three mix rounds, two finalizer
// multiplies, a final xor-shift stage and four 8-bit remainder stages
// reset: all stage valid bits clear, the hash seed returns to 1
// ---------------------------------------------------------------------------
// ecmp hash path select
// Seeded murmur3 x86_32 over the 12-byte flow key and next-hop choice as
// the hash modulo the saturated path count.
// ---------------------------------------------------------------------------
module ecmp_hash_path_select
	import ehps_pkg::*;
#(
	parameter int MAX_PATHS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        key_valid,
	output logic        key_stall,
	input  key_t        key,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	localparam int SatCount = (MAX_PATHS > 127) ? 127 : MAX_PATHS;
	localparam int HashStages = 8;
	localparam int AllStages  = HashStages + MOD_STAGES;

	function automatic logic [31:0] rotl15(input logic [31:0] x);
		return {x[16:0], x[31:17]};
	endfunction

	function automatic logic [31:0] mix(input logic [31:0] h, input logic [31:0] k);
		logic [31:0] r;
		r = h ^ k;
		r = {r[18:0], r[31:19]};
		return r + {r[29:0], 2'b00} + MIX_ADD;
	endfunction

	logic [31:0] seed_q;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        valid_s5, valid_s6, valid_s7, valid_s8;
	logic [31:0] m0_s1, m1_s1, m2_s1;
	logic [31:0] k0_s2, k1_s2, k2_s2;
	logic [31:0] k1_s3, k2_s3, k2_s4;
	logic [31:0] h_s3, h_s4, h_s5, h_s6, h_s7;
	mod_t        data_s8;
	logic [6:0]  cnt_s1, cnt_s2, cnt_s3, cnt_s4, cnt_s5, cnt_s6, cnt_s7;

	logic [AllStages:1]   stage_vld;
	logic [AllStages+1:1] rdy;

	logic [31:0] ports;
	logic [6:0]  cnt_in;
	logic [31:0] fin6, fin7;

	logic [MOD_STAGES:0] mod_vld;
	mod_t                mod_data [MOD_STAGES+1];

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd1;
		end else if (cfg_wr_en) begin
			seed_q <= cfg_wr_data;
		end
	end

	// ready chain: a stage loads when empty or when its successor moves
	assign stage_vld[HashStages:1] = {valid_s8, valid_s7, valid_s6, valid_s5,
		valid_s4, valid_s3, valid_s2, valid_s1};
	assign stage_vld[AllStages:HashStages+1] = mod_vld[MOD_STAGES:1];
	assign rdy[AllStages+1] = !res_stall;

	for (genvar g = 1; g <= AllStages; g++) begin : g_rdy
		assign rdy[g] = !stage_vld[g] || rdy[g+1];
	end

	assign key_stall = !rdy[1];

	// port word and path count saturation
	always_comb begin
		unique case (key.protocol)
			PROTO_TCP, PROTO_UDP, PROTO_PORTS_FC, PROTO_PORTS_FD: begin
				ports = {key.dst_port, key.src_port};
			end
			default: begin
				ports = 32'd0;
			end
		endcase
		cnt_in = (key.path_count > 7'(SatCount)) ? 7'(SatCount) : key.path_count;
	end

	// finalizer xor-shifts ahead of each multiply
	always_comb begin
		fin6 = h_s5 ^ KEY_BYTES;
		fin6 = fin6 ^ (fin6 >> 16);
		fin7 = h_s6 ^ (h_s6 >> 13);
	end

	// hash stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (rdy[1]) valid_s1 <= key_valid;
			if (rdy[2]) valid_s2 <= valid_s1;
			if (rdy[3]) valid_s3 <= valid_s2;
			if (rdy[4]) valid_s4 <= valid_s3;
			if (rdy[5]) valid_s5 <= valid_s4;
			if (rdy[6]) valid_s6 <= valid_s5;
			if (rdy[7]) valid_s7 <= valid_s6;
			if (rdy[8]) valid_s8 <= valid_s7;
		end
	end

	// key words times c1
	always_ff @(posedge clk) begin
		if (rdy[1] && key_valid) begin
			m0_s1  <= key.src_addr * C1;
			m1_s1  <= key.dst_addr * C1;
			m2_s1  <= ports * C1;
			cnt_s1 <= cnt_in;
		end
	end

	// rotate and multiply by c2
	always_ff @(posedge clk) begin
		if (rdy[2] && valid_s1) begin
			k0_s2  <= rotl15(m0_s1) * C2;
			k1_s2  <= rotl15(m1_s1) * C2;
			k2_s2  <= rotl15(m2_s1) * C2;
			cnt_s2 <= cnt_s1;
		end
	end

	// mix rounds, one block each
	always_ff @(posedge clk) begin
		if (rdy[3] && valid_s2) begin
			h_s3   <= mix(seed_q, k0_s2);
			k1_s3  <= k1_s2;
			k2_s3  <= k2_s2;
			cnt_s3 <= cnt_s2;
		end
		if (rdy[4] && valid_s3) begin
			h_s4   <= mix(h_s3, k1_s3);
			k2_s4  <= k2_s3;
			cnt_s4 <= cnt_s3;
		end
		if (rdy[5] && valid_s4) begin
			h_s5   <= mix(h_s4, k2_s4);
			cnt_s5 <= cnt_s4;
		end
	end

	// finalizer
	always_ff @(posedge clk) begin
		if (rdy[6] && valid_s5) begin
			h_s6   <= fin6 * F1;
			cnt_s6 <= cnt_s5;
		end
		if (rdy[7] && valid_s6) begin
			h_s7   <= fin7 * F2;
			cnt_s7 <= cnt_s6;
		end
		if (rdy[8] && valid_s7) begin
			data_s8.hash <= h_s7 ^ (h_s7 >> 16);
			data_s8.rem  <= 7'd0;
			data_s8.cnt  <= cnt_s7;
		end
	end

	// remainder pipeline
	assign mod_vld[0]  = valid_s8;
	assign mod_data[0] = data_s8;

	for (genvar j = 0; j < MOD_STAGES; j++) begin : g_mod
		ehps_mod_stage #(
			.SLICE(j)
		) u_mod (
			.clk        (clk),
			.arst_n     (arst_n),
			.load       (rdy[HashStages+1+j]),
			.prev_valid (mod_vld[j]),
			.prev       (mod_data[j]),
			.valid_s1   (mod_vld[j+1]),
			.data_s1    (mod_data[j+1])
		);
	end

	// result item
	assign res_valid      = mod_vld[MOD_STAGES];
	assign res.flow_hash  = mod_data[MOD_STAGES].hash;
	assign res.no_route   = (mod_data[MOD_STAGES].cnt == 7'd0);
	assign res.path_index = res.no_route ? 6'd0 : mod_data[MOD_STAGES].rem[5:0];

endmodule

// File: hdl/ehps_checker.sv
// ---------------------------------------------------------------------------
// ecmp hash path select checker
// Port-level checks on item conservation, result holding, the no-route
// encoding and the quiet reset, bound to the top level.
// ---------------------------------------------------------------------------
module ehps_checker
	import ehps_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic key_valid,
	input logic key_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	localparam int Depth = 12;

	logic [3:0] inflight_q;
	logic       key_acc;
	logic       res_acc;

	assign key_acc = key_valid && !key_stall;
	assign res_acc = res_valid && !res_stall;

	// items inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 4'd0;
		end else begin
			unique case ({key_acc, res_acc})
				2'b10:   inflight_q <= inflight_q + 4'd1;
				2'b01:   inflight_q <= inflight_q - 4'd1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed under stall");

	// no route always points at next hop zero
	a_no_route_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.no_route |-> res.path_index == 6'd0)
		else $error("no route with nonzero path index");

	// never more items inside than stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 4'(Depth))
		else $error("more items inside than pipeline stages");

	// every result belongs to an accepted item
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> inflight_q != 4'd0)
		else $error("result without an accepted item");

	// nothing is shown once reset has been seen
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !res_valid)
		else $error("result valid during reset");

endmodule

bind ecmp_hash_path_select ehps_checker u_ehps_checker (.*);
